@@ hw/rtl/dmxtx_pkg.sv @@
`timescale 1ns / 1ps

package dmxtx_pkg;

    localparam int MAX_CHANNELS = 512;
    localparam int COUNT_W      = 10;
    localparam int BREAK_W      = 6;
    localparam int MAB_W        = 3;
    localparam int CFG_DATA_W   = 10;
    localparam int CFG_INDEX_W  = 2;
    localparam int BIT_CNT_W    = 6;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QUEUE_PTR_W  = 1;
    localparam int QUEUE_CNT_W  = 2;

    // Bit times of one 8N2 character: start, eight data, two stop
    localparam int CHAR_BITS = 11;

    localparam logic [COUNT_W-1:0] CHANNEL_COUNT_RST = COUNT_W'(MAX_CHANNELS);
    localparam logic [BREAK_W-1:0] BREAK_RST = 6'd22;
    localparam logic [BREAK_W-1:0] BREAK_MIN = 6'd22;
    localparam logic [BREAK_W-1:0] BREAK_MAX = 6'd36;
    localparam logic [MAB_W-1:0]   MAB_RST   = 3'd3;
    localparam logic [MAB_W-1:0]   MAB_MIN   = 3'd3;
    localparam logic [MAB_W-1:0]   MAB_MAX   = 3'd6;

    // Register indexes on the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_COUNT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BREAK_BITS    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MAB_BITS      = 2'd2;

    // One classified item handed from the front end to the serializer
    typedef struct packed {
        logic [7:0]         value;
        logic               first;
        logic               last;
        logic [BREAK_W-1:0] brk;
        logic [MAB_W-1:0]   mab;
    } dmxtx_desc_t;

    typedef struct packed {
        logic valid;
        logic full;
    } dmxtx_qstat_t;

endpackage

@@ hw/rtl/dmxtx_front.sv @@
`timescale 1ns / 1ps

module dmxtx_front
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [dmxtx_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [dmxtx_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                  accept,
    input  logic [7:0]                            channel_value,
    output dmxtx_pkg::dmxtx_desc_t                desc
);

    logic [dmxtx_pkg::COUNT_W-1:0] count_cfg_reg;
    logic [dmxtx_pkg::BREAK_W-1:0] brk_cfg_reg;
    logic [dmxtx_pkg::MAB_W-1:0]   mab_cfg_reg;
    logic [dmxtx_pkg::COUNT_W-1:0] index_reg;
    logic [dmxtx_pkg::COUNT_W-1:0] index_next;
    logic [dmxtx_pkg::COUNT_W-1:0] count_eff;
    logic                          last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_cfg_reg <= dmxtx_pkg::CHANNEL_COUNT_RST;
            brk_cfg_reg   <= dmxtx_pkg::BREAK_RST;
            mab_cfg_reg   <= dmxtx_pkg::MAB_RST;
            index_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    dmxtx_pkg::REG_CHANNEL_COUNT:
                        count_cfg_reg <= cfg_data[dmxtx_pkg::COUNT_W-1:0];
                    dmxtx_pkg::REG_BREAK_BITS:
                        brk_cfg_reg <= cfg_data[dmxtx_pkg::BREAK_W-1:0];
                    dmxtx_pkg::REG_MAB_BITS:
                        mab_cfg_reg <= cfg_data[dmxtx_pkg::MAB_W-1:0];
                    default:
                        ;
                endcase
            end
            if (accept)
                index_reg <= index_next;
        end
    end

    // Saturate the channel count into 1..MAX_CHANNELS
    always_comb
    begin
        if (count_cfg_reg > dmxtx_pkg::COUNT_W'(dmxtx_pkg::MAX_CHANNELS))
            count_eff = dmxtx_pkg::COUNT_W'(dmxtx_pkg::MAX_CHANNELS);
        else if (count_cfg_reg == '0)
            count_eff = dmxtx_pkg::COUNT_W'(1);
        else
            count_eff = count_cfg_reg;
    end

    assign last = ({1'b0, index_reg} + 11'd1) >= {1'b0, count_eff};
    assign index_next = last ? '0 : index_reg + dmxtx_pkg::COUNT_W'(1);

    always_comb
    begin
        desc.value = channel_value;
        desc.first = (index_reg == '0);
        desc.last  = last;
        if (brk_cfg_reg < dmxtx_pkg::BREAK_MIN)
            desc.brk = dmxtx_pkg::BREAK_MIN;
        else if (brk_cfg_reg > dmxtx_pkg::BREAK_MAX)
            desc.brk = dmxtx_pkg::BREAK_MAX;
        else
            desc.brk = brk_cfg_reg;
        if (mab_cfg_reg < dmxtx_pkg::MAB_MIN)
            desc.mab = dmxtx_pkg::MAB_MIN;
        else if (mab_cfg_reg > dmxtx_pkg::MAB_MAX)
            desc.mab = dmxtx_pkg::MAB_MAX;
        else
            desc.mab = mab_cfg_reg;
    end

endmodule

@@ hw/rtl/dmxtx_queue.sv @@
`timescale 1ns / 1ps

module dmxtx_queue
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       wr,
    input  dmxtx_pkg::dmxtx_desc_t     wr_desc,
    input  logic                       rd,
    output dmxtx_pkg::dmxtx_desc_t     rd_desc,
    output dmxtx_pkg::dmxtx_qstat_t    stat
);

    dmxtx_pkg::dmxtx_desc_t             mem [dmxtx_pkg::QUEUE_DEPTH];
    logic [dmxtx_pkg::QUEUE_PTR_W-1:0]  wr_ptr_reg;
    logic [dmxtx_pkg::QUEUE_PTR_W-1:0]  rd_ptr_reg;
    logic [dmxtx_pkg::QUEUE_CNT_W-1:0]  cnt_reg;
    logic [dmxtx_pkg::QUEUE_CNT_W-1:0]  cnt_next;

    always_ff @(posedge clk)
    begin
        if (wr)
            mem[wr_ptr_reg] <= wr_desc;
    end

    assign rd_desc = mem[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (wr && !rd)
            cnt_next = cnt_reg + dmxtx_pkg::QUEUE_CNT_W'(1);
        else if (rd && !wr)
            cnt_next = cnt_reg - dmxtx_pkg::QUEUE_CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (wr)
                wr_ptr_reg <= wr_ptr_reg + dmxtx_pkg::QUEUE_PTR_W'(1);
            if (rd)
                rd_ptr_reg <= rd_ptr_reg + dmxtx_pkg::QUEUE_PTR_W'(1);
            cnt_reg <= cnt_next;
        end
    end

    assign stat.valid = (cnt_reg != '0);
    assign stat.full  = (cnt_reg == dmxtx_pkg::QUEUE_CNT_W'(dmxtx_pkg::QUEUE_DEPTH));

endmodule

@@ hw/rtl/dmxtx_back.sv @@
`timescale 1ns / 1ps

module dmxtx_back
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  dmxtx_pkg::dmxtx_desc_t     desc,
    input  logic                       desc_valid,
    output logic                       desc_take,
    input  logic                       pop,
    output logic                       empty,
    output logic                       line_level,
    output logic                       last_of_item,
    output logic                       frame_end,
    output logic                       busy
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_BREAK = 5'b00010,
        ST_MAB   = 5'b00100,
        ST_SCODE = 5'b01000,
        ST_DATA  = 5'b10000
    } state_t;

    localparam logic [dmxtx_pkg::BIT_CNT_W-1:0] CHAR_END =
        dmxtx_pkg::BIT_CNT_W'(dmxtx_pkg::CHAR_BITS - 1);
    localparam logic [dmxtx_pkg::BIT_CNT_W-1:0] DATA_END = dmxtx_pkg::BIT_CNT_W'(8);

    state_t                              state_reg, state_next;
    logic [dmxtx_pkg::BIT_CNT_W-1:0]     cnt_reg, cnt_next;
    logic [7:0]                          byte_reg, byte_next;
    logic                                fend_reg, fend_next;
    logic [dmxtx_pkg::BREAK_W-1:0]       brk_reg, brk_next;
    logic [dmxtx_pkg::MAB_W-1:0]         mab_reg, mab_next;
    logic                                out_valid_reg, out_valid_next;
    logic                                line_reg, eoi_reg, efe_reg;
    logic                                advance;
    logic                                char_done;
    logic                                lvl, eoi, efe;
    logic [2:0]                          data_sel;

    assign advance   = (state_reg != ST_IDLE) && (!out_valid_reg || pop);
    assign char_done = (cnt_reg == CHAR_END);
    assign data_sel  = cnt_reg[2:0] - 3'd1;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        byte_next  = byte_reg;
        fend_next  = fend_reg;
        brk_next   = brk_reg;
        mab_next   = mab_reg;
        lvl        = 1'b1;
        eoi        = 1'b0;
        efe        = 1'b0;
        desc_take  = 1'b0;

        case (state_reg)
            ST_IDLE:
                desc_take = desc_valid;
            ST_BREAK:
            begin
                lvl = 1'b0;
                if (advance)
                begin
                    if (cnt_reg == brk_reg - dmxtx_pkg::BREAK_W'(1))
                    begin
                        state_next = ST_MAB;
                        cnt_next   = '0;
                    end
                    else
                        cnt_next = cnt_reg + dmxtx_pkg::BIT_CNT_W'(1);
                end
            end
            ST_MAB:
            begin
                lvl = 1'b1;
                if (advance)
                begin
                    if (cnt_reg == {3'b000, mab_reg - dmxtx_pkg::MAB_W'(1)})
                    begin
                        state_next = ST_SCODE;
                        cnt_next   = '0;
                    end
                    else
                        cnt_next = cnt_reg + dmxtx_pkg::BIT_CNT_W'(1);
                end
            end
            ST_SCODE:
            begin
                // Start code is zero: only the stop bits are high
                lvl = (cnt_reg > DATA_END);
                if (advance)
                begin
                    if (char_done)
                    begin
                        state_next = ST_DATA;
                        cnt_next   = '0;
                    end
                    else
                        cnt_next = cnt_reg + dmxtx_pkg::BIT_CNT_W'(1);
                end
            end
            ST_DATA:
            begin
                if (cnt_reg == '0)
                    lvl = 1'b0;
                else if (cnt_reg <= DATA_END)
                    lvl = byte_reg[data_sel];
                else
                    lvl = 1'b1;
                eoi = char_done;
                efe = char_done && fend_reg;
                if (advance)
                begin
                    if (char_done)
                    begin
                        // chain straight into the next item when one waits
                        desc_take  = desc_valid;
                        state_next = ST_IDLE;
                    end
                    else
                        cnt_next = cnt_reg + dmxtx_pkg::BIT_CNT_W'(1);
                end
            end
            default:
                state_next = ST_IDLE;
        endcase

        if (desc_take)
        begin
            state_next = desc.first ? ST_BREAK : ST_DATA;
            cnt_next   = '0;
            byte_next  = desc.value;
            fend_next  = desc.last;
            brk_next   = desc.brk;
            mab_next   = desc.mab;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (pop)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg  <= cnt_next;
        byte_reg <= byte_next;
        fend_reg <= fend_next;
        brk_reg  <= brk_next;
        mab_reg  <= mab_next;
        if (advance)
        begin
            line_reg <= lvl;
            eoi_reg  <= eoi;
            efe_reg  <= efe;
        end
    end

    assign empty        = !out_valid_reg;
    assign line_level   = line_reg;
    assign last_of_item = eoi_reg;
    assign frame_end    = efe_reg;
    assign busy         = (state_reg != ST_IDLE);

endmodule

@@ hw/rtl/dmx512_frame_transmitter_core.sv @@
`timescale 1ns / 1ps

// DMX512 frame transmitter core.
// Input channel: push a channel byte on channel_value while full is low; it is
// taken at that clock edge. Result channel: while empty is low, line_level,
// last_of_item and frame_end describe one 4 us bit time of the line; pop takes it.
// Each byte yields eleven bit times (start, eight data LSB first, two stop).
// The first byte of a frame is preceded by a break, a mark after break and a
// zero start code, so it yields break + mab + 22 bit times.
// Configuration: cfg_we writes cfg_data into register cfg_index at the clock
// edge (0 channel count, 1 break bits, 2 mark after break bits); write only idle.
// Path: a taken item is written into the queue, then loaded by the serializer,
// and its first bit time is then registered for the result ports. Throughput:
// one bit time per cycle while the receiver pops; the serializer sets this.
// A two-entry queue between classifier and serializer lets the next byte be
// pushed while the current one is still going out.
// Reset clears the channel index (next byte starts a frame), the queue and the
// output valid flag, and loads 512 channels, 22 break and 3 mark bit times.
// When the receiver stalls, the current bit time holds and the serializer waits.

module dmx512_frame_transmitter_core
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [dmxtx_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [dmxtx_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                  push,
    output logic                                  full,
    input  logic [7:0]                            channel_value,
    input  logic                                  pop,
    output logic                                  empty,
    output logic                                  line_level,
    output logic                                  last_of_item,
    output logic                                  frame_end
);

    dmxtx_pkg::dmxtx_desc_t   front_desc;
    dmxtx_pkg::dmxtx_desc_t   q_desc;
    dmxtx_pkg::dmxtx_qstat_t  q_stat;
    logic                     accept;
    logic                     q_take;
    logic                     back_busy;

    // Take an item only while the queue has room
    assign full   = q_stat.full;
    assign accept = push && !q_stat.full;

    // Classify: track the channel index, mark frame start and end, saturate timing
    dmxtx_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .accept        (accept),
        .channel_value (channel_value),
        .desc          (front_desc)
    );

    dmxtx_queue u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (accept),
        .wr_desc (front_desc),
        .rd      (q_take),
        .rd_desc (q_desc),
        .stat    (q_stat)
    );

    // Serialize: one bit time per cycle into the output register while the receiver pops
    dmxtx_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .desc         (q_desc),
        .desc_valid   (q_stat.valid),
        .desc_take    (q_take),
        .pop          (pop),
        .empty        (empty),
        .line_level   (line_level),
        .last_of_item (last_of_item),
        .frame_end    (frame_end),
        .busy         (back_busy)
    );

    // Serializer takes from the queue only when it holds an item
    assert property (@(posedge clk) disable iff (!rst_n) q_take |-> q_stat.valid)
        else $error("serializer took from an empty queue");

    // An accepted item is waiting in the queue on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n) accept |=> q_stat.valid)
        else $error("accepted item missing from queue");

    // Frame end only on the final bit time of an item
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && frame_end) |-> last_of_item)
        else $error("frame end without item end");

    // The final bit time of an item is a stop bit, always high
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && last_of_item) |-> line_level)
        else $error("item did not end on a high stop bit");

    // The serializer is never idle while an item waits in the queue
    assert property (@(posedge clk) disable iff (!rst_n)
        (q_stat.valid && !back_busy) |-> q_take)
        else $error("serializer left an item waiting");

endmodule

@@ tb/sv/dmx512_frame_transmitter_core_checker.sv @@
`timescale 1ns / 1ps

module dmx512_frame_transmitter_core_checker
    import dmxtx_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   push,
    input  logic                   full,
    input  logic [7:0]             channel_value,
    input  logic                   pop,
    input  logic                   empty,
    input  logic                   line_level,
    input  logic                   last_of_item,
    input  logic                   frame_end,
    output int                     errors,
    output int                     pending
);

    // One predicted bit time on the line
    typedef struct packed {
        logic level;
        logic byte_end;
        logic frame_done;
    } bit_slot_t;

    bit_slot_t          line_bits_due[$];
    logic [COUNT_W-1:0] count_reg;
    logic [BREAK_W-1:0] break_reg;
    logic [MAB_W-1:0]   mab_reg;
    logic [COUNT_W-1:0] chan_idx;

    // Queue one 8N2 character; flags ride on the second stop bit
    task automatic queue_char(input logic [7:0] data, input logic byte_end,
                              input logic frame_done);
        bit_slot_t slot;
        slot = '{level: 1'b0, byte_end: 1'b0, frame_done: 1'b0};
        line_bits_due.push_back(slot);
        for (int i = 0; i < 8; i++)
        begin
            slot.level = data[i];
            line_bits_due.push_back(slot);
        end
        slot.level = 1'b1;
        line_bits_due.push_back(slot);
        slot.byte_end   = byte_end;
        slot.frame_done = frame_done;
        line_bits_due.push_back(slot);
    endtask

    task automatic queue_channel_bits(input logic [7:0] value);
        int        eff_count;
        int        brk_len;
        int        mab_len;
        logic      ends_frame;
        bit_slot_t slot;
        eff_count = (count_reg > MAX_CHANNELS) ? MAX_CHANNELS : int'(count_reg);
        if (eff_count == 0)
            eff_count = 1;
        ends_frame = (int'(chan_idx) + 1) >= eff_count;
        if (chan_idx == '0)
        begin
            brk_len = (break_reg < BREAK_MIN) ? int'(BREAK_MIN) :
                      (break_reg > BREAK_MAX) ? int'(BREAK_MAX) : int'(break_reg);
            mab_len = (mab_reg < MAB_MIN) ? int'(MAB_MIN) :
                      (mab_reg > MAB_MAX) ? int'(MAB_MAX) : int'(mab_reg);
            slot = '{level: 1'b0, byte_end: 1'b0, frame_done: 1'b0};
            repeat (brk_len) line_bits_due.push_back(slot);
            slot.level = 1'b1;
            repeat (mab_len) line_bits_due.push_back(slot);
            queue_char(8'h00, 1'b0, 1'b0);
        end
        queue_char(value, 1'b1, ends_frame);
        chan_idx = ends_frame ? '0 : chan_idx + 1'b1;
    endtask

    task automatic report_field(input string name, input logic want, input logic got);
        if (got !== want)
        begin
            $error("%s: expected %0b, got %0b", name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        bit_slot_t want;
        if (!rst_n)
        begin
            count_reg = CHANNEL_COUNT_RST;
            break_reg = BREAK_RST;
            mab_reg   = MAB_RST;
            chan_idx  = '0;
            line_bits_due.delete();
        end
        else
        begin
            // Compare first: a pop never belongs to an item taken at the same edge
            if (pop && !empty)
            begin
                if (line_bits_due.size() == 0)
                begin
                    $error("bit time with no item pending: line_level %0b", line_level);
                    errors++;
                end
                else
                begin
                    want = line_bits_due.pop_front();
                    report_field("line_level", want.level, line_level);
                    report_field("last_of_item", want.byte_end, last_of_item);
                    report_field("frame_end", want.frame_done, frame_end);
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_CHANNEL_COUNT: count_reg = cfg_data[COUNT_W-1:0];
                    REG_BREAK_BITS:    break_reg = cfg_data[BREAK_W-1:0];
                    REG_MAB_BITS:      mab_reg   = cfg_data[MAB_W-1:0];
                    default:           ;
                endcase
            end
            if (push && !full)
                queue_channel_bits(channel_value);
        end
        pending = line_bits_due.size();
    end

endmodule

@@ tb/sv/tb_dmx512_frame_transmitter_core.sv @@
`timescale 1ns / 1ps

module tb_dmx512_frame_transmitter_core;

    import dmxtx_pkg::*;

    // Generous bound: every item a full frame start (64 bit times) with the
    // receiver idling most cycles still ends far below this.
    localparam int CYCLE_LIMIT     = 600_000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_CYCLES    = 12;
    localparam int BURST_ITEMS     = 10;

    // Index 3 maps to no register; a write there must change nothing
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   cfg_we        = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index     = '0;
    logic [CFG_DATA_W-1:0]  cfg_data      = '0;
    logic                   push          = 1'b0;
    logic [7:0]             channel_value = '0;
    logic                   pop           = 1'b0;
    logic                   full;
    logic                   empty;
    logic                   line_level;
    logic                   last_of_item;
    logic                   frame_end;

    int errors;
    int expected_bits;

    // Idle rates in percent, changed per phase by the stimulus process
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // Raised by the stimulus to make the receiver hold off for a long stretch
    bit hold_off_req = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    dmx512_frame_transmitter_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .push          (push),
        .full          (full),
        .channel_value (channel_value),
        .pop           (pop),
        .empty         (empty),
        .line_level    (line_level),
        .last_of_item  (last_of_item),
        .frame_end     (frame_end)
    );

    dmx512_frame_transmitter_core_checker line_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .push          (push),
        .full          (full),
        .channel_value (channel_value),
        .pop           (pop),
        .empty         (empty),
        .line_level    (line_level),
        .last_of_item  (last_of_item),
        .frame_end     (frame_end),
        .errors        (errors),
        .pending       (expected_bits)
    );

    // Offer one channel byte and hold it until the block takes it.
    // Idle cycles go in front, so push never drops between back-to-back items.
    task automatic send_item(input logic [7:0] value);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push          <= 1'b1;
        channel_value <= value;
        @(posedge clk);
        // full is sampled before this edge's updates land: low means taken
        while (full)
            @(posedge clk);
    endtask

    // Stop offering, drain every expected bit time, then give the serializer
    // a few more cycles so a register write never lands mid-character.
    task automatic settle_idle();
        push <= 1'b0;
        @(posedge clk);
        while (expected_bits != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Leave cfg_we high; the caller lowers it after the last write
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    task automatic program_regs(input logic [CFG_DATA_W-1:0] count,
                                input logic [CFG_DATA_W-1:0] brk,
                                input logic [CFG_DATA_W-1:0] mab);
        write_reg(REG_CHANNEL_COUNT, count);
        write_reg(REG_BREAK_BITS, brk);
        write_reg(REG_MAB_BITS, mab);
        cfg_we <= 1'b0;
    endtask

    // Receiver: pop at the phase's rate; on request hold pop low for a long
    // stretch so the block fills and pushes back on the sender.
    initial
    begin : pop_driver
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                hold_left    = HOLD_OFF_CYCLES;
                hold_off_req = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
                pop <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Bound the whole run by cycle count
    initial
    begin : watchdog
        int cycle_cnt;
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("dmx512_frame_transmitter_core verification failed");
        $finish;
    end

    initial
    begin : stimulus
        logic [CFG_DATA_W-1:0] count_pick;
        logic [CFG_DATA_W-1:0] break_pick;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: 512 channels, 22 break, 3 mark. Open a frame and
        // walk the data extremes and single-bit patterns through it.
        send_item(8'h00);
        send_item(8'hFF);
        send_item(8'h01);
        send_item(8'h80);
        send_item(8'h55);
        send_item(8'hAA);
        settle_idle();

        // One channel per frame, longest break and mark. The frame is six
        // channels in, so the count drop ends it on the very next byte.
        write_reg(REG_UNUSED, '1);
        program_regs(10'd1, CFG_DATA_W'(BREAK_MAX), CFG_DATA_W'(MAB_MAX));
        send_item(8'h3C);
        send_item(8'hC3);
        settle_idle();

        // Count zero acts as one; break and mark saturate up to their minimum
        program_regs('0, '0, '0);
        send_item(8'hFF);
        send_item(8'h00);
        settle_idle();

        // Count above the channel cap; break and mark saturate down
        program_regs('1, CFG_DATA_W'(6'h3F), CFG_DATA_W'(3'h7));
        send_item(8'h12);
        send_item(8'h34);
        settle_idle();

        // Four-channel frame cut to two after three bytes went out
        program_regs(10'd4, CFG_DATA_W'(BREAK_MIN), CFG_DATA_W'(MAB_MIN));
        send_item(8'h0F);
        send_item(8'hF0);
        send_item(8'h99);
        settle_idle();
        program_regs(10'd2, 10'd29, 10'd4);
        send_item(8'h66);
        send_item(8'h7E);
        settle_idle();

        // Random bursts under three idle mixes. Small channel counts keep
        // frames ending often; now and then the full count range and break
        // values outside the legal span come up.
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 14;
                    recv_idle_pct = 87;
                end
                1:
                begin
                    send_idle_pct = 87;
                    recv_idle_pct = 14;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int burst = 0; burst < 4; burst++)
            begin
                settle_idle();
                count_pick = ($urandom_range(0, 3) == 0)
                           ? CFG_DATA_W'($urandom_range(0, 1023))
                           : CFG_DATA_W'($urandom_range(0, 6));
                break_pick = ($urandom_range(0, 3) == 0)
                           ? CFG_DATA_W'($urandom_range(0, 63))
                           : CFG_DATA_W'($urandom_range(20, 38));
                program_regs(count_pick, break_pick, CFG_DATA_W'($urandom_range(0, 7)));
                // Long receiver stall while the sender keeps offering
                if (phase == 2 && burst == 1)
                    hold_off_req = 1'b1;
                repeat (BURST_ITEMS) send_item(8'($urandom_range(0, 255)));
            end
        end

        settle_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("dmx512_frame_transmitter_core verification clean");
        else
            $display("dmx512_frame_transmitter_core verification failed");
        $finish;
    end

endmodule
